>>> hw/rtl/tce_pkg.sv
// Shared types and constants for the transitive closure engine.
// No dependencies; used by transitive_closure_engine_unit.
package tce_pkg;

    localparam int DATA_W    = 64;  // adjacency / closure row width
    localparam int VC_W      = 7;   // vertex_count register width
    localparam int IDX_W     = 6;   // row_index result width
    localparam int APB_DW    = 32;  // configuration data width
    localparam int APB_AW    = 3;   // configuration byte address width

    localparam logic [VC_W-1:0] VC_RESET = 7'd64;

    // Register word index taken from the byte address
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_PIVOT = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

>>> hw/rtl/transitive_closure_engine_unit.sv
// Transitive closure engine: row loader, in-place Warshall closure over a
// one-port-read / one-port-write row memory, and closure row emitter.
// Depends on tce_pkg.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+------------------------------
//  request   | start & !busy                    | row_bits[63:0]
//  result    | result_valid                     | row_index, reach_bits, last_row
//  config    | psel & penable & pwrite & pready | paddr, pwdata (prdata on read)
//
// A row request that does not complete the matrix is written into the row
// memory and busy stays low. The request carrying row n-1 starts the closure: each
// pivot costs one pivot-row read plus n row read-modify-writes through the row
// memory, then an emit pass reads every row, and busy holds until that pass ends.
// Results leave one per cycle, in the cycle after each memory read of the
// emit pass, so the last row comes out in the first cycle with busy low.
// Reset clears the control state and sets vertex_count to 64; the row memory
// needs no clearing pass. The receiver cannot stall, so results are never
// held back.
module transitive_closure_engine_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [tce_pkg::DATA_W-1:0]      row_bits,
    // result channel
    output logic                            result_valid,
    output logic [tce_pkg::IDX_W-1:0]       row_index,
    output logic [tce_pkg::DATA_W-1:0]      reach_bits,
    output logic                            last_row,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tce_pkg::APB_AW-1:0]      paddr,
    input  logic [tce_pkg::APB_DW-1:0]      pwdata,
    output logic [tce_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    localparam int ROW_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [tce_pkg::VC_W-1:0] vc_reg;
    logic                     cfg_wr;
    logic                     cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == tce_pkg::REG_VERTEX_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = {{(tce_pkg::APB_DW - tce_pkg::VC_W){1'b0}}, vc_reg};
        end
    end

    // Effective vertex count: zero acts as one, large values saturate.
    logic [CNT_W-1:0] n_act;
    logic [ROW_W-1:0] last_idx;

    always_comb
    begin
        priority if (vc_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (vc_reg > tce_pkg::VC_W'(MAX_VERTICES))
        begin
            n_act = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_act = CNT_W'(vc_reg);
        end
    end

    assign last_idx = ROW_W'(n_act - CNT_W'(1));

    // Drop columns at or above the vertex count.
    logic [tce_pkg::DATA_W-1:0] col_mask;

    always_comb
    begin
        for (int j = 0; j < tce_pkg::DATA_W; j++)
        begin
            col_mask[j] = (tce_pkg::VC_W'(j) < tce_pkg::VC_W'(n_act));
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    tce_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]     rows_loaded_reg, rows_loaded_next;
    logic [ROW_W-1:0]     k_reg, k_next;           // pivot
    logic [ROW_W-1:0]     i_reg, i_next;           // sweep / emit row
    logic                 wb_valid_reg;            // row data returning for write-back
    logic [ROW_W-1:0]     wb_addr_reg;
    logic [ROW_W-1:0]     wb_k_reg;                // pivot of the returning row
    logic [tce_pkg::DATA_W-1:0] pivot_reg;

    logic                 accept;
    logic [ROW_W-1:0]     load_row;

    assign busy   = (state_reg != tce_pkg::ST_LOAD);
    assign accept = start && !busy;

    // A stale fill count restarts the matrix at row 0.
    assign load_row = (rows_loaded_reg >= n_act) ? '0 : ROW_W'(rows_loaded_reg);

    // ------------------------------------------------------------------
    // Row memory ports
    // ------------------------------------------------------------------
    logic                       mem_we;
    logic [ROW_W-1:0]           mem_waddr;
    logic [tce_pkg::DATA_W-1:0] mem_wdata;
    logic [ROW_W-1:0]           mem_raddr;
    logic [tce_pkg::DATA_W-1:0] rd_data_reg;
    logic [tce_pkg::DATA_W-1:0] wb_data;
    logic [tce_pkg::IDX_W-1:0]  k_col;

    logic [tce_pkg::DATA_W-1:0] row_mem [MAX_VERTICES];

    // OR the pivot row into a row that reaches the pivot; the pivot index
    // travels with the returning row, since k advances before the last
    // write-back of a pass lands.
    assign k_col   = tce_pkg::IDX_W'(wb_k_reg);
    assign wb_data = rd_data_reg[k_col] ? (rd_data_reg | pivot_reg) : rd_data_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = load_row;
        mem_wdata = row_bits & col_mask;
        if (wb_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr_reg;
            mem_wdata = wb_data;
        end
        else if (accept && !(cfg_wr && cfg_hit))
        begin
            mem_we = 1'b1;
        end
    end

    assign mem_raddr = (state_reg == tce_pkg::ST_PIVOT) ? k_reg : i_reg;

    // Forward a write-back to a read of the same row in the same cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && (mem_waddr == mem_raddr))
        begin
            rd_data_reg <= mem_wdata;
        end
        else
        begin
            rd_data_reg <= row_mem[mem_raddr];
        end
    end

    // Latch the pivot row on the first sweep cycle; it holds for the pass
    // since row k ORed with itself stays the same.
    always_ff @(posedge clk)
    begin
        if ((state_reg == tce_pkg::ST_SWEEP) && (i_reg == '0))
        begin
            pivot_reg <= rd_data_reg;
        end
        wb_addr_reg <= i_reg;
        wb_k_reg    <= k_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        rows_loaded_next = rows_loaded_reg;
        k_next           = k_reg;
        i_next           = i_reg;
        unique case (state_reg)
            tce_pkg::ST_LOAD:
            begin
                if (cfg_wr && cfg_hit)
                begin
                    // A vertex_count write abandons a partly loaded matrix.
                    rows_loaded_next = '0;
                end
                else if (accept)
                begin
                    if (load_row == last_idx)
                    begin
                        rows_loaded_next = '0;
                        k_next           = '0;
                        state_next       = tce_pkg::ST_PIVOT;
                    end
                    else
                    begin
                        rows_loaded_next = CNT_W'(load_row) + CNT_W'(1);
                    end
                end
            end
            tce_pkg::ST_PIVOT:
            begin
                i_next     = '0;
                state_next = tce_pkg::ST_SWEEP;
            end
            tce_pkg::ST_SWEEP:
            begin
                if (i_reg == last_idx)
                begin
                    i_next = '0;
                    if (k_reg == last_idx)
                    begin
                        state_next = tce_pkg::ST_EMIT;
                    end
                    else
                    begin
                        k_next     = k_reg + ROW_W'(1);
                        state_next = tce_pkg::ST_PIVOT;
                    end
                end
                else
                begin
                    i_next = i_reg + ROW_W'(1);
                end
            end
            tce_pkg::ST_EMIT:
            begin
                if (i_reg == last_idx)
                begin
                    i_next     = '0;
                    state_next = tce_pkg::ST_LOAD;
                end
                else
                begin
                    i_next = i_reg + ROW_W'(1);
                end
            end
            default:
            begin
                state_next = tce_pkg::ST_LOAD;
            end
        endcase
    end

    logic                      result_valid_reg;
    logic [tce_pkg::IDX_W-1:0] row_index_reg;
    logic                      last_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tce_pkg::ST_LOAD;
            rows_loaded_reg  <= '0;
            k_reg            <= '0;
            i_reg            <= '0;
            wb_valid_reg     <= 1'b0;
            vc_reg           <= tce_pkg::VC_RESET;
            result_valid_reg <= 1'b0;
            row_index_reg    <= '0;
            last_row_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rows_loaded_reg  <= rows_loaded_next;
            k_reg            <= k_next;
            i_reg            <= i_next;
            wb_valid_reg     <= (state_reg == tce_pkg::ST_SWEEP);
            result_valid_reg <= (state_reg == tce_pkg::ST_EMIT);
            row_index_reg    <= tce_pkg::IDX_W'(i_reg);
            last_row_reg     <= (i_reg == last_idx);
            if (cfg_wr && cfg_hit)
            begin
                vc_reg <= pwdata[tce_pkg::VC_W-1:0];
            end
        end
    end

    // Emitted row data comes straight from the registered memory read.
    assign result_valid = result_valid_reg;
    assign row_index    = row_index_reg;
    assign last_row     = last_row_reg;
    assign reach_bits   = rd_data_reg;

endmodule
